>>> src/zts_pkg.sv
// ----------------------------------------------------------------------------
// zts_pkg
// Types, geometry codes and zone tables for the track/sector to block unit.
// ----------------------------------------------------------------------------
package zts_pkg;

  localparam int GeoW   = 3;
  localparam int TrackW = 8;
  localparam int SectW  = 8;
  localparam int AddrW  = 13;
  localparam int TrelW  = 7;
  localparam int SptW   = 6;
  localparam int BaseW  = 11;
  localparam int SideW  = 12;

  localparam logic [GeoW-1:0] GEO_35_SINGLE = 3'd0;
  localparam logic [GeoW-1:0] GEO_35_DOUBLE = 3'd1;
  localparam logic [GeoW-1:0] GEO_77_SINGLE = 3'd2;
  localparam logic [GeoW-1:0] GEO_77_DOUBLE = 3'd3;
  localparam logic [GeoW-1:0] GEO_FLAT      = 3'd4;

  localparam logic [TrackW-1:0] SIDE35_TRACKS = 8'd35;
  localparam logic [TrackW-1:0] SIDE77_TRACKS = 8'd77;
  localparam logic [TrackW-1:0] FLAT_TRACKS   = 8'd80;
  localparam logic [SideW-1:0]  SIDE35_BLOCKS = 12'd683;
  localparam logic [SideW-1:0]  SIDE77_BLOCKS = 12'd2083;

  typedef enum logic [1:0] {
    KIND_Z35,
    KIND_Z77,
    KIND_FLAT
  } kind_t;

  typedef struct packed {
    logic [TrelW-1:0] first;
    logic [SptW-1:0]  spt;
    logic [BaseW-1:0] base;
  } zone_t;

  // stage a result: side-relative track
  typedef struct packed {
    logic              ok;
    kind_t             kind;
    logic [TrelW-1:0]  t_rel;
    logic [SectW-1:0]  sector;
    logic [SideW-1:0]  side_add;
  } dec_t;

  // stage b result: zone resolved
  typedef struct packed {
    logic              ok;
    logic [TrelW-1:0]  trk_off;
    logic [SptW-1:0]   spt;
    logic [BaseW-1:0]  base;
    logic [SectW-1:0]  sector;
    logic [SideW-1:0]  side_add;
  } zone_beat_t;

  function automatic zone_t zone_of(kind_t kind, logic [TrelW-1:0] t_rel);
    zone_t z;
    z = '0;
    unique case (kind)
      KIND_Z35: begin
        if (t_rel <= 7'd17)      z = '{first: 7'd1,  spt: 6'd21, base: 11'd0};
        else if (t_rel <= 7'd24) z = '{first: 7'd18, spt: 6'd19, base: 11'd357};
        else if (t_rel <= 7'd30) z = '{first: 7'd25, spt: 6'd18, base: 11'd490};
        else                     z = '{first: 7'd31, spt: 6'd17, base: 11'd598};
      end
      KIND_Z77: begin
        if (t_rel <= 7'd39)      z = '{first: 7'd1,  spt: 6'd29, base: 11'd0};
        else if (t_rel <= 7'd53) z = '{first: 7'd40, spt: 6'd27, base: 11'd1131};
        else if (t_rel <= 7'd64) z = '{first: 7'd54, spt: 6'd25, base: 11'd1509};
        else                     z = '{first: 7'd65, spt: 6'd23, base: 11'd1784};
      end
      KIND_FLAT: z = '{first: 7'd1, spt: 6'd40, base: 11'd0};
      default:   z = '0;
    endcase
    return z;
  endfunction

endpackage

>>> src/zts_zone.sv
// ----------------------------------------------------------------------------
// zts_zone
// Stages a and b: geometry decode, side split and zone lookup.
// ----------------------------------------------------------------------------
module zts_zone (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [zts_pkg::GeoW-1:0]     geometry,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [zts_pkg::TrackW-1:0]   in_track,
  input  logic [zts_pkg::SectW-1:0]    in_sector,
  output logic                         zb_valid,
  input  logic                         zb_ready,
  output zts_pkg::zone_beat_t          zb_beat
);
  import zts_pkg::*;

  logic       a_valid_r;
  dec_t       a_r;
  dec_t       a_nxt;
  logic       a_ready;
  logic       b_valid_r;
  zone_beat_t b_r;
  zone_beat_t b_nxt;
  logic       b_ready;
  zone_t      zone;
  logic       trk_ok;

  assign b_ready  = !b_valid_r || zb_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign in_ready = a_ready;

  // stage a: geometry decode
  always_comb begin
    a_nxt          = '0;
    a_nxt.sector   = in_sector;
    a_nxt.t_rel    = in_track[TrelW-1:0];
    a_nxt.kind     = KIND_Z35;
    trk_ok         = in_track != '0;
    unique case (geometry)
      GEO_35_SINGLE: begin
        a_nxt.ok = trk_ok && in_track <= SIDE35_TRACKS;
      end
      GEO_35_DOUBLE: begin
        a_nxt.ok = trk_ok && in_track <= (SIDE35_TRACKS << 1);
        if (in_track > SIDE35_TRACKS) begin
          a_nxt.t_rel    = TrelW'(in_track - SIDE35_TRACKS);
          a_nxt.side_add = SIDE35_BLOCKS;
        end
      end
      GEO_77_SINGLE: begin
        a_nxt.kind = KIND_Z77;
        a_nxt.ok   = trk_ok && in_track <= SIDE77_TRACKS;
      end
      GEO_77_DOUBLE: begin
        a_nxt.kind = KIND_Z77;
        a_nxt.ok   = trk_ok && in_track <= (SIDE77_TRACKS << 1);
        if (in_track > SIDE77_TRACKS) begin
          a_nxt.t_rel    = TrelW'(in_track - SIDE77_TRACKS);
          a_nxt.side_add = SIDE77_BLOCKS;
        end
      end
      GEO_FLAT: begin
        a_nxt.kind = KIND_FLAT;
        a_nxt.ok   = trk_ok && in_track <= FLAT_TRACKS;
      end
      default: a_nxt.ok = 1'b0;
    endcase
  end

  // stage b: zone lookup and sector check
  always_comb begin
    zone             = zone_of(a_r.kind, a_r.t_rel);
    b_nxt.trk_off    = a_r.t_rel - zone.first;
    b_nxt.spt        = zone.spt;
    b_nxt.base       = zone.base;
    b_nxt.sector     = a_r.sector;
    b_nxt.side_add   = a_r.side_add;
    b_nxt.ok         = a_r.ok && (a_r.sector < {{(SectW-SptW){1'b0}}, zone.spt});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_ready) a_valid_r <= in_valid;
      if (b_ready) b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) a_r <= a_nxt;
    if (b_ready && a_valid_r) b_r <= b_nxt;
  end

  assign zb_valid = b_valid_r;
  assign zb_beat  = b_r;

endmodule

>>> src/zts_addr.sv
// ----------------------------------------------------------------------------
// zts_addr
// Stages c and d: track offset multiply, base sum and final address.
// ----------------------------------------------------------------------------
module zts_addr (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        zb_valid,
  output logic                        zb_ready,
  input  zts_pkg::zone_beat_t         zb_beat,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [zts_pkg::AddrW-1:0]   out_block_address,
  output logic                        out_valid_res
);
  import zts_pkg::*;

  logic             c_valid_r;
  logic             c_ok_r;
  logic [AddrW-1:0] c_prod_r;
  logic [AddrW-1:0] c_sum_r;
  logic [AddrW-1:0] c_prod_nxt;
  logic [AddrW-1:0] c_sum_nxt;
  logic             c_ready;
  logic             d_valid_r;
  logic             d_ok_r;
  logic [AddrW-1:0] d_addr_r;
  logic [AddrW-1:0] d_addr_nxt;
  logic             d_ready;

  assign d_ready  = !d_valid_r || out_ready;
  assign c_ready  = !c_valid_r || d_ready;
  assign zb_ready = c_ready;

  assign c_prod_nxt = AddrW'(zb_beat.trk_off) * AddrW'(zb_beat.spt);
  assign c_sum_nxt  = AddrW'(zb_beat.base) + AddrW'(zb_beat.side_add)
                    + AddrW'(zb_beat.sector);
  assign d_addr_nxt = c_ok_r ? (c_prod_r + c_sum_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
    end else begin
      if (c_ready) c_valid_r <= zb_valid;
      if (d_ready) d_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && zb_valid) begin
      c_ok_r   <= zb_beat.ok;
      c_prod_r <= c_prod_nxt;
      c_sum_r  <= c_sum_nxt;
    end
    if (d_ready && c_valid_r) begin
      d_ok_r   <= c_ok_r;
      d_addr_r <= d_addr_nxt;
    end
  end

  assign out_valid         = d_valid_r;
  assign out_block_address = d_addr_r;
  assign out_valid_res     = d_ok_r;

endmodule

>>> src/zoned_track_sector_to_block_unit.sv
// ----------------------------------------------------------------------------
// zoned_track_sector_to_block_unit
// Maps a 1-based track and a sector to a linear block address for one of
// five disk geometries selected by the geometry register.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid/in_ready   | in_track, in_sector
//   out     | output    | out_valid/out_ready | out_block_address, out_valid_res
//   cfg     | input     | cfg_we              | cfg_wdata (geometry)
//
// four register stages, one beat per cycle sustained while out is not stalled
// each stage holds its beat while the next one is full and stalled, so a
// stall on out only backs up the stages behind it, bubbles collapse
// synchronous active-low reset empties the pipeline and sets geometry to 0
// ----------------------------------------------------------------------------
module zoned_track_sector_to_block_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [zts_pkg::GeoW-1:0]    cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [zts_pkg::TrackW-1:0]  in_track,
  input  logic [zts_pkg::SectW-1:0]   in_sector,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [zts_pkg::AddrW-1:0]   out_block_address,
  output logic                        out_valid_res
);
  import zts_pkg::*;

  logic [GeoW-1:0] geometry_r;
  logic            zb_valid;
  logic            zb_ready;
  zone_beat_t      zb_beat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geometry_r <= GEO_35_SINGLE;
    end else if (cfg_we) begin
      geometry_r <= cfg_wdata;
    end
  end

  zts_zone u_zone (
    .clk       (clk),
    .rst_n     (rst_n),
    .geometry  (geometry_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_track  (in_track),
    .in_sector (in_sector),
    .zb_valid  (zb_valid),
    .zb_ready  (zb_ready),
    .zb_beat   (zb_beat)
  );

  zts_addr u_addr (
    .clk               (clk),
    .rst_n             (rst_n),
    .zb_valid          (zb_valid),
    .zb_ready          (zb_ready),
    .zb_beat           (zb_beat),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_block_address (out_block_address),
    .out_valid_res     (out_valid_res)
  );

endmodule

>>> src/zts_checker.sv
// ----------------------------------------------------------------------------
// zts_checker
// Port-level checks on the track/sector to block unit, bound to the top.
// ----------------------------------------------------------------------------
module zts_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [zts_pkg::AddrW-1:0]   out_block_address,
  input logic                        out_valid_res
);
  import zts_pkg::*;

  localparam logic [AddrW-1:0] MaxAddr = 13'd4165;

  // illegal requests carry a zero address
  a_illegal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_block_address == '0)
    else $error("illegal beat with nonzero address");

  // legal addresses stay inside the largest geometry
  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_res |-> out_block_address <= MaxAddr)
    else $error("block address out of range");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_block_address)
      && $stable(out_valid_res))
    else $error("stalled result beat changed");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

endmodule

bind zoned_track_sector_to_block_unit zts_checker u_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_block_address (out_block_address),
  .out_valid_res     (out_valid_res)
);
